>>> rtl/core/bmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bmm_pkg;

    localparam int LEFT_MAX  = 256;
    localparam int RIGHT_MAX = 256;
    localparam int EDGE_MAX  = 4096;

    // field width of vertices and counts
    localparam int VW  = 9;
    // edge pointer, zero is the null link
    localparam int EW  = $clog2(EDGE_MAX + 1);
    localparam int LAW = $clog2(LEFT_MAX);
    localparam int RAW = $clog2(RIGHT_MAX);
    localparam int EAW = $clog2(EDGE_MAX);
    // frames held in the stack memory below the top frame
    localparam int SPW = $clog2(LEFT_MAX);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ROOT,
        ST_HEAD,
        ST_EVAL,
        ST_EDGE,
        ST_PART,
        ST_POP,
        ST_POPL,
        ST_AUGS,
        ST_AUGE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic run_init;
        logic root_issue;
        logic head_load;
        logic edge_issue;
        logic skip_edge;
        logic visit;
        logic skip_link;
        logic push;
        logic stack_issue;
        logic frame_load;
        logic aug_top;
        logic aug_write;
        logic next_root;
        logic count_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic run_accept;
        logic root_over;
        logic e_zero;
        logic sp_zero;
        logic seen;
        logic w_zero;
        logic stk_full;
        logic out_busy;
    } t_sts;

    function automatic logic [LAW-1:0] lidx(input logic [VW-1:0] v);
        logic [VW-1:0] t;
        t = v - VW'(1);
        return t[LAW-1:0];
    endfunction

    function automatic logic [RAW-1:0] ridx(input logic [VW-1:0] v);
        logic [VW-1:0] t;
        t = v - VW'(1);
        return t[RAW-1:0];
    endfunction

    function automatic logic [EAW-1:0] eidx(input logic [EW-1:0] e);
        logic [EW-1:0] t;
        t = e - EW'(1);
        return t[EAW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/bmm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/core/bmm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bmm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bmm_pkg::t_sts i_sts,
    output bmm_pkg::t_cmd      o_cmd
);
    import bmm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_sts.run_accept) n_state = ST_START;
            ST_START: n_state = ST_ROOT;
            ST_ROOT:  n_state = i_sts.root_over ? ST_DONE : ST_HEAD;
            ST_HEAD:  n_state = ST_EVAL;
            ST_EVAL: begin
                if (!i_sts.e_zero) n_state = ST_EDGE;
                else if (i_sts.sp_zero) n_state = ST_ROOT;
                else n_state = ST_POP;
            end
            ST_EDGE:  n_state = i_sts.seen ? ST_EVAL : ST_PART;
            ST_PART: begin
                if (i_sts.w_zero) n_state = i_sts.sp_zero ? ST_ROOT : ST_AUGS;
                else if (i_sts.stk_full) n_state = ST_EVAL;
                else n_state = ST_HEAD;
            end
            ST_POP:   n_state = ST_POPL;
            ST_POPL:  n_state = ST_EVAL;
            ST_AUGS:  n_state = ST_AUGE;
            ST_AUGE:  n_state = i_sts.sp_zero ? ST_ROOT : ST_AUGS;
            ST_DONE:  if (!i_sts.out_busy) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.in_ready = 1'b1;
            ST_START: o_cmd.run_init = 1'b1;
            ST_ROOT:  o_cmd.root_issue = !i_sts.root_over;
            ST_HEAD:  o_cmd.head_load = 1'b1;
            ST_EVAL: begin
                o_cmd.edge_issue  = !i_sts.e_zero;
                o_cmd.next_root   = i_sts.e_zero && i_sts.sp_zero;
                o_cmd.stack_issue = i_sts.e_zero && !i_sts.sp_zero;
            end
            ST_EDGE: begin
                o_cmd.skip_edge = i_sts.seen;
                o_cmd.visit     = !i_sts.seen;
            end
            ST_PART: begin
                o_cmd.aug_top     = i_sts.w_zero;
                o_cmd.next_root   = i_sts.w_zero && i_sts.sp_zero;
                o_cmd.count_inc   = i_sts.w_zero && i_sts.sp_zero;
                o_cmd.stack_issue = i_sts.w_zero && !i_sts.sp_zero;
                o_cmd.skip_link   = !i_sts.w_zero && i_sts.stk_full;
                o_cmd.push        = !i_sts.w_zero && !i_sts.stk_full;
            end
            ST_POP:   o_cmd.frame_load = 1'b1;
            ST_POPL:  o_cmd.skip_edge = 1'b1;
            ST_AUGS:  o_cmd.frame_load = 1'b1;
            ST_AUGE: begin
                o_cmd.aug_write   = 1'b1;
                o_cmd.next_root   = i_sts.sp_zero;
                o_cmd.count_inc   = i_sts.sp_zero;
                o_cmd.stack_issue = !i_sts.sp_zero;
            end
            ST_DONE:  o_cmd.out_load = !i_sts.out_busy;
            default:  o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/bmm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bmm_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bmm_pkg::t_cmd                      i_cmd,
    output bmm_pkg::t_sts                           o_sts,
    input  wire logic                               i_in_valid,
    input  wire logic [bmm_pkg::IN_TDATA_W-1:0]     i_in_data,
    input  wire logic                               i_in_user,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [bmm_pkg::OUT_TDATA_W-1:0]    o_out_data,
    input  wire logic                               i_cfg_valid,
    input  wire logic [bmm_pkg::VW-1:0]             i_cfg_data
);
    import bmm_pkg::*;

    // control state
    logic [VW-1:0]        r_num_left;
    logic [EW-1:0]        r_edge_total;
    logic                 r_ovf;
    logic                 r_add_pend;
    logic [LEFT_MAX-1:0]  r_hvalid;
    logic [RIGHT_MAX-1:0] r_pvalid;
    logic [RIGHT_MAX-1:0] r_visited;
    logic                 r_out_valid;

    // payload
    logic [VW-1:0]  r_a, r_b;
    logic           r_hv_rd, r_fwd_hit, r_pv_rd;
    logic [EW-1:0]  r_fwd_val;
    logic [VW-1:0]  r_root, r_limit, r_count;
    logic [VW-1:0]  r_cur_v, r_v;
    logic [EW-1:0]  r_cur_e, r_link;
    logic [SPW-1:0] r_sp;
    logic [VW-1:0]  r_out_cnt;
    logic           r_out_ovf;

    logic           in_fire, in_cmd;
    logic [VW-1:0]  in_a, in_b;
    logic           add_ok, full, commit_store;
    logic [EW-1:0]  head_val, total_inc;

    logic           head_re;
    logic [LAW-1:0] head_ra;
    logic [EW-1:0]  head_rdata;
    logic           n_fwd_hit;

    logic           edge_re;
    logic [EAW-1:0] edge_ra;
    logic [EW+VW-1:0] edge_rdata;
    logic [VW-1:0]  e_tgt;
    logic [EW-1:0]  e_link;

    logic           part_we;
    logic [RAW-1:0] part_wa;
    logic [VW-1:0]  part_rdata, w;

    logic           stk_re;
    logic [SPW-1:0] stk_ra;
    logic [VW+EW-1:0] stk_rdata;
    logic [VW-1:0]  s_v;
    logic [EW-1:0]  s_e;

    assign in_fire = i_in_valid && i_cmd.in_ready;
    assign in_cmd  = i_in_user;
    assign in_a    = i_in_data[VW-1:0];
    assign in_b    = i_in_data[2*VW-1:VW];

    assign total_inc = r_edge_total + EW'(1);
    assign full      = (r_edge_total == EW'(EDGE_MAX));
    assign add_ok    = r_add_pend && (r_a != '0) && (r_a <= VW'(LEFT_MAX))
                       && (r_b != '0) && (r_b <= VW'(RIGHT_MAX));
    assign commit_store = add_ok && !full;

    assign head_val = r_fwd_hit ? r_fwd_val : (r_hv_rd ? head_rdata : '0);

    assign e_tgt  = edge_rdata[VW-1:0];
    assign e_link = edge_rdata[VW+EW-1:VW];
    assign s_v    = stk_rdata[VW+EW-1:EW];
    assign s_e    = stk_rdata[EW-1:0];
    assign w      = r_pv_rd ? part_rdata : '0;

    // head memory read: add lookup, root setup or descent
    always_comb begin
        head_re   = 1'b0;
        head_ra   = lidx(in_a);
        n_fwd_hit = 1'b0;
        if (in_fire && in_cmd == CMD_ADD) begin
            head_re   = 1'b1;
            n_fwd_hit = commit_store && (r_a == in_a);
        end else if (i_cmd.root_issue) begin
            head_re = 1'b1;
            head_ra = lidx(r_root);
        end else if (i_cmd.push) begin
            head_re = 1'b1;
            head_ra = lidx(w);
        end
    end

    always_comb begin
        edge_re = i_cmd.edge_issue || i_cmd.frame_load;
        edge_ra = i_cmd.frame_load ? eidx(s_e) : eidx(r_cur_e);
    end

    always_comb begin
        part_we = i_cmd.aug_top || i_cmd.aug_write;
        part_wa = i_cmd.aug_write ? ridx(e_tgt) : ridx(r_v);
    end

    assign stk_re = i_cmd.stack_issue;
    assign stk_ra = r_sp - SPW'(1);

    bmm_ram #(.WIDTH(EW), .DEPTH(LEFT_MAX)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (commit_store),
        .i_waddr (lidx(r_a)),
        .i_wdata (total_inc),
        .i_re    (head_re),
        .i_raddr (head_ra),
        .o_rdata (head_rdata)
    );

    bmm_ram #(.WIDTH(EW + VW), .DEPTH(EDGE_MAX)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (commit_store),
        .i_waddr (r_edge_total[EAW-1:0]),
        .i_wdata ({head_val, r_b}),
        .i_re    (edge_re),
        .i_raddr (edge_ra),
        .o_rdata (edge_rdata)
    );

    bmm_ram #(.WIDTH(VW), .DEPTH(RIGHT_MAX)) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (part_wa),
        .i_wdata (r_cur_v),
        .i_re    (i_cmd.visit),
        .i_raddr (ridx(e_tgt)),
        .o_rdata (part_rdata)
    );

    bmm_ram #(.WIDTH(VW + EW), .DEPTH(LEFT_MAX)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_sp),
        .i_wdata ({r_cur_v, r_cur_e}),
        .i_re    (stk_re),
        .i_raddr (stk_ra),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_left   <= VW'(LEFT_MAX);
            r_edge_total <= '0;
            r_ovf        <= 1'b0;
            r_add_pend   <= 1'b0;
            r_hvalid     <= '0;
            r_pvalid     <= '0;
            r_visited    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_num_left <= i_cfg_data;
            r_add_pend <= in_fire && in_cmd == CMD_ADD;
            if (add_ok && full) r_ovf <= 1'b1;
            if (commit_store) begin
                r_edge_total      <= total_inc;
                r_hvalid[lidx(r_a)] <= 1'b1;
            end
            if (i_cmd.run_init) r_pvalid <= '0;
            if (part_we) r_pvalid[part_wa] <= 1'b1;
            if (i_cmd.root_issue) r_visited <= '0;
            if (i_cmd.visit) r_visited[ridx(e_tgt)] <= 1'b1;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= in_a;
            r_b <= in_b;
        end
        if (head_re) begin
            r_hv_rd   <= r_hvalid[head_ra];
            r_fwd_hit <= n_fwd_hit;
            r_fwd_val <= total_inc;
        end
        if (i_cmd.visit) begin
            r_pv_rd <= r_pvalid[ridx(e_tgt)];
            r_v     <= e_tgt;
            r_link  <= e_link;
        end
        if (i_cmd.run_init) begin
            r_root  <= VW'(1);
            r_count <= '0;
            r_limit <= (r_num_left > VW'(LEFT_MAX)) ? VW'(LEFT_MAX) : r_num_left;
        end
        if (i_cmd.next_root) r_root <= r_root + VW'(1);
        if (i_cmd.count_inc) r_count <= r_count + VW'(1);
        if (i_cmd.root_issue) begin
            r_cur_v <= r_root;
            r_sp    <= '0;
        end
        if (i_cmd.head_load) r_cur_e <= head_val;
        if (i_cmd.skip_edge) r_cur_e <= e_link;
        if (i_cmd.skip_link) r_cur_e <= r_link;
        if (i_cmd.push) begin
            r_sp    <= r_sp + SPW'(1);
            r_cur_v <= w;
        end
        if (i_cmd.stack_issue) r_sp <= stk_ra;
        if (i_cmd.frame_load) r_cur_v <= s_v;
        if (i_cmd.out_load) begin
            r_out_cnt <= r_count;
            r_out_ovf <= r_ovf;
        end
    end

    always_comb begin
        o_sts.run_accept = in_fire && in_cmd == CMD_RUN;
        o_sts.root_over  = r_root > r_limit;
        o_sts.e_zero     = r_cur_e == '0;
        o_sts.sp_zero    = r_sp == '0;
        o_sts.seen       = r_visited[ridx(e_tgt)];
        o_sts.w_zero     = w == '0;
        o_sts.stk_full   = r_sp == SPW'(LEFT_MAX - 1);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W - VW - 1){1'b0}}, r_out_ovf, r_out_cnt};
endmodule
`default_nettype wire

>>> rtl/core/bipartite_max_matching_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Maximum bipartite matching by augmenting-path search. Send add-edge items
// (tuser = 0) to build per-left-vertex adjacency lists, newest edge first, in
// a 4096-entry edge memory; while the block is idle, one add is taken every
// cycle. Edges with a vertex of zero or above 256 are ignored; edges
// arriving with the store full are dropped and set a sticky overflow flag,
// cleared only by reset. A run item (tuser = 1) clears the partner table and
// tries left vertices 1..num_left (values above 256 act as 256) with a
// depth-first search on an explicit stack, then returns one transfer with the
// match count and the flag, after any wait for the output register. Each
// search step issues at most one read, to one of the single-read-port
// memories (head, edge, partner, stack). Input is not taken while a run is
// in progress; a finished result waits in the output register while further
// adds are accepted. num_left must be written only while the block is idle;
// the block itself does not enforce this. No clearing pass is needed after
// reset.
module bipartite_max_matching_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [8:0] left_vertex, [17:9] right_vertex, [23:18] zero
    input  wire logic [23:0] i_s_axis_tdata,
    // [0] cmd: 0 add edge, 1 run
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [8:0] match_count, [9] edges_dropped, [15:10] zero
    output logic [15:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    // num_left
    input  wire logic [8:0]  i_cfg_data
);
    import bmm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes are always accepted
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = cmd.in_ready;

    bmm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bmm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser[0]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data)
    );
endmodule
`default_nettype wire

>>> rtl/core/bmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bmm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic [23:0] i_s_axis_tdata,
    input wire logic [0:0]  i_s_axis_tuser,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata
);
    import bmm_pkg::*;

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // match count bounded by the maximum left vertex count, padding zero
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[8:0] <= 9'(LEFT_MAX))
                            && (o_m_axis_tdata[15:10] == '0))
        else $error("match count out of range");

    // input closed once a run transfer is taken
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser[0] == CMD_RUN)
            |=> !o_s_axis_tready)
        else $error("input open during run");
endmodule

bind bipartite_max_matching_top bmm_checker u_bmm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
